// ===== design/rtn_pkg.sv =====
// ---------------------------------------------------------------------------
// rtn_pkg
// Shared types and constants of the RGB to NV12 converter.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rtn_pkg;

    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int MAX_HEIGHT_DEF = 4096;

    localparam int FRAME_WIDTH_RST  = 1920;
    localparam int FRAME_HEIGHT_RST = 1080;

    // configuration register indexes
    localparam logic [1:0] CFG_BYTE_ORDER   = 2'd0;
    localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd2;

    localparam logic BYTE_ORDER_BGRA = 1'b0;

    // luma weights
    localparam logic [6:0] Y_KR   = 7'd66;
    localparam logic [7:0] Y_KG   = 8'd129;
    localparam logic [4:0] Y_KB   = 5'd25;
    localparam logic [7:0] Y_RND  = 8'd128;
    localparam logic [7:0] Y_OFS  = 8'd16;

    // chroma weights on four-pixel sums, with bias 128*1024 + 512
    localparam logic signed [19:0] CB_KR  = -20'sd38;
    localparam logic signed [19:0] CB_KG  = -20'sd74;
    localparam logic signed [19:0] CB_KB  = 20'sd112;
    localparam logic signed [19:0] CR_KR  = 20'sd112;
    localparam logic signed [19:0] CR_KG  = -20'sd94;
    localparam logic signed [19:0] CR_KB  = -20'sd18;
    localparam logic signed [19:0] C_BIAS = 20'sd131584;
    localparam int                 C_SHIFT = 10;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } t_rgb;

    typedef struct packed {
        t_rgb        cur;
        logic [9:0]  r4;
        logic [9:0]  g4;
        logic [9:0]  b4;
        logic        chroma_valid;
        logic [10:0] chroma_row;
        logic [11:0] chroma_col;
        logic        frame_end;
    } t_rtn_item;

    localparam int ITEM_W = $bits(t_rtn_item);

endpackage

`default_nettype wire

// ===== design/rgb_to_nv12_converter_core.sv =====
// a result passes the stage register, the queue and the output register on its way out
// throughput: one pixel per cycle while the output is not stalled; the line buffer takes one write
// or one read per pixel, so no port conflict ever stalls the stream
// reset: position, byte order and the stage, queue and output valids clear at once, dimensions
// return to their reset values; the line buffer is not cleared and no clearing pass is needed
// ---------------------------------------------------------------------------
// rgb_to_nv12_converter_core
// Streaming BT.601 limited-range RGB to NV12 converter, one luma sample per
// pixel and one chroma pair per 2x2 block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rgb_to_nv12_converter_core import rtn_pkg::*; #(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [12:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_pixel_byte0,
    input  wire logic [7:0]  i_pixel_byte1,
    input  wire logic [7:0]  i_pixel_byte2,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [7:0]       o_luma,
    output logic             o_chroma_valid,
    output logic [10:0]      o_chroma_row,
    output logic [11:0]      o_chroma_col,
    output logic [7:0]       o_cb,
    output logic [7:0]       o_cr,
    output logic             o_frame_end
);

    logic      q_push;
    logic      q_pop;
    logic      q_full;
    logic      q_empty;
    t_rtn_item q_in;
    t_rtn_item q_out;

    assign o_cfg_ready = 1'b1;

    rtn_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid && o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_pixel_byte0 (i_pixel_byte0),
        .i_pixel_byte1 (i_pixel_byte1),
        .i_pixel_byte2 (i_pixel_byte2),
        .i_q_full      (q_full),
        .o_q_push      (q_push),
        .o_q_item      (q_in)
    );

    rtn_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_item  (q_out)
    );

    rtn_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_q_item       (q_out),
        .o_q_pop        (q_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_luma         (o_luma),
        .o_chroma_valid (o_chroma_valid),
        .o_chroma_row   (o_chroma_row),
        .o_chroma_col   (o_chroma_col),
        .o_cb           (o_cb),
        .o_cr           (o_cr),
        .o_frame_end    (o_frame_end)
    );

    // chroma fields are zero on items that carry no chroma pair
    a_chroma_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_chroma_valid |->
            o_cb == 8'd0 && o_cr == 8'd0 && o_chroma_row == 11'd0 && o_chroma_col == 12'd0)
        else $error("chroma fields set without chroma_valid");

    // the last pixel of a frame always closes a block
    a_frame_end_chroma: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_frame_end |-> o_chroma_valid)
        else $error("frame end without chroma pair");

    a_luma_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_luma >= 8'd16 && o_luma <= 8'd235)
        else $error("luma out of limited range");

    // the queue never takes an item while full
    a_queue_guard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> !q_push)
        else $error("push into a full queue");

endmodule

`default_nettype wire

// ===== design/rtn_ram.sv =====
// ---------------------------------------------------------------------------
// rtn_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rtn_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== design/rtn_front.sv =====
// ---------------------------------------------------------------------------
// rtn_front
// Takes pixels, tracks the raster position, keeps the even-row line buffer
// and gathers each 2x2 block's channel sums.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rtn_front import rtn_pkg::*; #(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [12:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_pixel_byte0,
    input  wire logic [7:0]  i_pixel_byte1,
    input  wire logic [7:0]  i_pixel_byte2,
    input  wire logic        i_q_full,
    output logic             o_q_push,
    output t_rtn_item        o_q_item
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int WW = CW + 1;
    localparam int HW = RW + 1;
    localparam int W_RST = (FRAME_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : FRAME_WIDTH_RST;
    localparam int H_RST = (FRAME_HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : FRAME_HEIGHT_RST;

    typedef struct packed {
        t_rgb        cur;
        t_rgb        left;
        logic        row_odd;
        logic        col_odd;
        logic        last_row;
        logic        last_col;
        logic [10:0] chroma_row;
        logic [11:0] chroma_col;
    } t_stage;

    logic          r_byte_order;
    logic [WW-1:0] r_width;
    logic [HW-1:0] r_height;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    t_rgb          r_left;
    t_rgb          r_prev_top;
    logic          r_s1_valid;
    t_stage        r_s1;

    logic          n_byte_order;
    logic [WW-1:0] n_width;
    logic [HW-1:0] n_height;

    logic          accept;
    t_rgb          cur;
    logic          row_odd;
    logic          last_col;
    logic          last_row;
    t_rgb          top;
    t_rgb          p00;
    t_rgb          p01;
    t_rgb          p10;
    t_rgb          p11;

    // ---- configuration, dimensions held clamped to 1..max
    always_comb begin
        n_byte_order = r_byte_order;
        n_width      = r_width;
        n_height     = r_height;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BYTE_ORDER: begin
                    n_byte_order = i_cfg_data[0];
                end
                CFG_FRAME_WIDTH: begin
                    if (i_cfg_data == 13'd0) begin
                        n_width = WW'(1);
                    end else if (32'(i_cfg_data) > 32'(MAX_WIDTH)) begin
                        n_width = WW'(MAX_WIDTH);
                    end else begin
                        n_width = WW'(i_cfg_data);
                    end
                end
                CFG_FRAME_HEIGHT: begin
                    if (i_cfg_data == 13'd0) begin
                        n_height = HW'(1);
                    end else if (32'(i_cfg_data) > 32'(MAX_HEIGHT)) begin
                        n_height = HW'(MAX_HEIGHT);
                    end else begin
                        n_height = HW'(i_cfg_data);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // ---- accept side
    assign o_stall  = r_s1_valid && i_q_full;
    assign o_q_push = r_s1_valid && !i_q_full;
    assign accept   = i_valid && !o_stall;

    always_comb begin
        cur.g = i_pixel_byte1;
        if (r_byte_order == BYTE_ORDER_BGRA) begin
            cur.r = i_pixel_byte2;
            cur.b = i_pixel_byte0;
        end else begin
            cur.r = i_pixel_byte0;
            cur.b = i_pixel_byte2;
        end
    end

    assign row_odd  = r_row[0];
    assign last_col = ({1'b0, r_col} + WW'(1)) >= r_width;
    assign last_row = ({1'b0, r_row} + HW'(1)) >= r_height;

    // even rows write the line buffer, odd rows read the entry above
    rtn_ram #(
        .WIDTH ($bits(t_rgb)),
        .DEPTH (MAX_WIDTH)
    ) u_line_buf (
        .i_clk   (i_clk),
        .i_we    (accept && !row_odd),
        .i_waddr (r_col),
        .i_wdata (cur),
        .i_re    (accept && row_odd),
        .i_raddr (r_col),
        .o_rdata (top)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_order <= 1'b0;
            r_width      <= WW'(W_RST);
            r_height     <= HW'(H_RST);
            r_col        <= '0;
            r_row        <= '0;
            r_left       <= '0;
            r_s1_valid   <= 1'b0;
        end else begin
            r_byte_order <= n_byte_order;
            r_width      <= n_width;
            r_height     <= n_height;
            if (accept) begin
                r_left     <= cur;
                r_s1_valid <= 1'b1;
                if (last_col) begin
                    r_col <= '0;
                    r_row <= last_row ? '0 : r_row + RW'(1);
                end else begin
                    r_col <= r_col + CW'(1);
                end
            end else if (o_q_push) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1.cur        <= cur;
            r_s1.left       <= r_left;
            r_s1.row_odd    <= row_odd;
            r_s1.col_odd    <= r_col[0];
            r_s1.last_row   <= last_row;
            r_s1.last_col   <= last_col;
            r_s1.chroma_row <= 11'(32'(r_row) >> 1);
            r_s1.chroma_col <= 12'(32'(r_col) & ~32'd1);
        end
        // top-left pixel of the block, kept for the odd column
        if (o_q_push && r_s1.row_odd) begin
            r_prev_top <= top;
        end
    end

    // ---- block gather, missing neighbours take the top-left pixel
    always_comb begin
        if (r_s1.row_odd) begin
            if (r_s1.col_odd) begin
                p00 = r_prev_top;
                p01 = top;
                p10 = r_s1.left;
                p11 = r_s1.cur;
            end else begin
                p00 = top;
                p01 = top;
                p10 = r_s1.cur;
                p11 = top;
            end
        end else begin
            if (r_s1.col_odd) begin
                p00 = r_s1.left;
                p01 = r_s1.cur;
                p10 = r_s1.left;
                p11 = r_s1.left;
            end else begin
                p00 = r_s1.cur;
                p01 = r_s1.cur;
                p10 = r_s1.cur;
                p11 = r_s1.cur;
            end
        end
    end

    always_comb begin
        o_q_item.cur  = r_s1.cur;
        o_q_item.r4   = 10'(p00.r) + 10'(p01.r) + 10'(p10.r) + 10'(p11.r);
        o_q_item.g4   = 10'(p00.g) + 10'(p01.g) + 10'(p10.g) + 10'(p11.g);
        o_q_item.b4   = 10'(p00.b) + 10'(p01.b) + 10'(p10.b) + 10'(p11.b);
        o_q_item.chroma_valid = (r_s1.row_odd || r_s1.last_row)
                              && (r_s1.col_odd || r_s1.last_col);
        o_q_item.chroma_row   = r_s1.chroma_row;
        o_q_item.chroma_col   = r_s1.chroma_col;
        o_q_item.frame_end    = r_s1.last_row && r_s1.last_col;
    end

endmodule

`default_nettype wire

// ===== design/rtn_queue.sv =====
// ---------------------------------------------------------------------------
// rtn_queue
// Two-entry register queue between the front and the back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rtn_queue import rtn_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  wire t_rtn_item i_item,
    output logic           o_full,
    input  wire logic      i_pop,
    output logic           o_empty,
    output t_rtn_item      o_item
);

    t_rtn_item  r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_item  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule

`default_nettype wire

// ===== design/rtn_back.sv =====
// ---------------------------------------------------------------------------
// rtn_back
// Luma and chroma arithmetic, into the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rtn_back import rtn_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_q_empty,
    input  wire t_rtn_item i_q_item,
    output logic           o_q_pop,
    output logic           o_valid,
    input  wire logic      i_stall,
    output logic [7:0]     o_luma,
    output logic           o_chroma_valid,
    output logic [10:0]    o_chroma_row,
    output logic [11:0]    o_chroma_col,
    output logic [7:0]     o_cb,
    output logic [7:0]     o_cr,
    output logic           o_frame_end
);

    logic                r_valid;
    logic [7:0]          r_luma;
    logic                r_chroma_valid;
    logic [10:0]         r_chroma_row;
    logic [11:0]         r_chroma_col;
    logic [7:0]          r_cb;
    logic [7:0]          r_cr;
    logic                r_frame_end;

    logic [16:0]         y_sum;
    logic signed [19:0]  r4_s;
    logic signed [19:0]  g4_s;
    logic signed [19:0]  b4_s;
    logic signed [19:0]  cb_sum;
    logic signed [19:0]  cr_sum;

    assign o_q_pop = !i_q_empty && (!r_valid || !i_stall);

    always_comb begin
        y_sum = 17'(Y_KR) * 17'(i_q_item.cur.r) + 17'(Y_KG) * 17'(i_q_item.cur.g)
              + 17'(Y_KB) * 17'(i_q_item.cur.b) + 17'(Y_RND);
        r4_s   = signed'(20'(i_q_item.r4));
        g4_s   = signed'(20'(i_q_item.g4));
        b4_s   = signed'(20'(i_q_item.b4));
        // bias keeps the sum positive, so the shift is a floor
        cb_sum = CB_KR * r4_s + CB_KG * g4_s + CB_KB * b4_s + C_BIAS;
        cr_sum = CR_KR * r4_s + CR_KG * g4_s + CR_KB * b4_s + C_BIAS;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_luma         <= y_sum[15:8] + Y_OFS;
            r_chroma_valid <= i_q_item.chroma_valid;
            r_frame_end    <= i_q_item.frame_end;
            if (i_q_item.chroma_valid) begin
                r_chroma_row <= i_q_item.chroma_row;
                r_chroma_col <= i_q_item.chroma_col;
                r_cb         <= cb_sum[C_SHIFT+7:C_SHIFT];
                r_cr         <= cr_sum[C_SHIFT+7:C_SHIFT];
            end else begin
                r_chroma_row <= '0;
                r_chroma_col <= '0;
                r_cb         <= '0;
                r_cr         <= '0;
            end
        end
    end

    assign o_valid        = r_valid;
    assign o_luma         = r_luma;
    assign o_chroma_valid = r_chroma_valid;
    assign o_chroma_row   = r_chroma_row;
    assign o_chroma_col   = r_chroma_col;
    assign o_cb           = r_cb;
    assign o_cr           = r_cr;
    assign o_frame_end    = r_frame_end;

endmodule

`default_nettype wire
